// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the symbol address lookup block (used by sal_ctrl).
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define SAL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication form: the consequent is checked on the cycle after the antecedent.
`define SAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sal_pkg.sv =====
// Shared types and constants for the symbol address lookup block.
// No dependencies; imported by every module of the block.
package sal_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 12;
    localparam int TYPE_W      = 8;

    localparam logic [TYPE_W-1:0] TYPE_LOWER_T = 8'h74;
    localparam logic [TYPE_W-1:0] TYPE_UPPER_T = 8'h54;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        logic              accepted;
        logic              found;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] offset;
    } result_t;

endpackage

// ===== rtl/sal_table.sv =====
// Sorted entry storage: one write port and one read port with registered read data.
// Depends on sal_pkg for the entry and request types.
module sal_table import sal_pkg::*; (
    input  logic     aclk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sal_ctrl.sv =====
// Sequencer for the lookup block: binary search, entry shifting and insertion.
// Depends on sal_pkg and assert_macros.svh; drives the sal_table port.
`include "assert_macros.svh"

module sal_ctrl import sal_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [ADDR_W-1:0] s_addr,
    input  logic [TYPE_W-1:0] s_sym_type,
    output mem_req_t          req,
    input  entry_t            rd_data,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROBE  = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_FETCH  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              func_reg, func_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    result_t           res_reg, res_next;

    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] lo_dec;
    logic [CNT_W-1:0] idx_dec;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] cnt_dec;
    logic             type_ok;
    logic             full;
    logic             reject;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_dec  = lo_reg - CNT_W'(1);
    assign idx_dec = idx_reg - CNT_W'(1);
    assign idx_inc = idx_reg + CNT_W'(1);
    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign type_ok = (s_sym_type == TYPE_LOWER_T) || (s_sym_type == TYPE_UPPER_T);
    assign full    = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign reject  = (s_addr == '0) || !type_ok || full;

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        idx_next   = idx_reg;
        func_next  = func_reg;
        addr_next  = addr_reg;
        res_next   = res_reg;
        req        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next = s_func;
                    addr_next = s_addr;
                    lo_next   = '0;
                    hi_next   = cnt_reg;
                    if (s_func == FUNC_LOAD && reject) begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (lo_reg < hi_reg) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = mid[IDX_W-1:0];
                    mid_next    = mid;
                    state_next  = S_CMP;
                end else if (func_reg == FUNC_LOAD) begin
                    if (lo_reg == cnt_reg) begin
                        state_next = S_INSERT;
                    end else begin
                        // Move the tail up by one, starting from the last entry.
                        idx_next    = cnt_dec;
                        req.rd_en   = 1'b1;
                        req.rd_addr = cnt_dec[IDX_W-1:0];
                        state_next  = S_SHIFT;
                    end
                end else if (lo_reg == '0) begin
                    res_next   = '0;
                    state_next = S_DONE;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = lo_dec[IDX_W-1:0];
                    state_next  = S_FETCH;
                end
            end
            S_CMP: begin
                if (rd_data.start <= addr_reg) begin
                    lo_next = mid_reg + CNT_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = S_PROBE;
            end
            S_SHIFT: begin
                // rd_data holds entry idx_reg; the next read overlaps this write.
                req.we      = 1'b1;
                req.wr_addr = idx_inc[IDX_W-1:0];
                req.wr_data = rd_data;
                if (idx_reg == lo_reg) begin
                    state_next = S_INSERT;
                end else begin
                    idx_next    = idx_dec;
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_dec[IDX_W-1:0];
                end
            end
            S_INSERT: begin
                req.we            = 1'b1;
                req.wr_addr       = lo_reg[IDX_W-1:0];
                req.wr_data.start = addr_reg;
                req.wr_data.tag   = cnt_reg[TAG_W-1:0];
                cnt_next          = cnt_reg + CNT_W'(1);
                res_next.accepted = 1'b1;
                res_next.found    = 1'b0;
                res_next.tag      = cnt_reg[TAG_W-1:0];
                res_next.offset   = '0;
                state_next        = S_DONE;
            end
            S_FETCH: begin
                res_next.accepted = 1'b0;
                res_next.found    = 1'b1;
                res_next.tag      = rd_data.tag;
                res_next.offset   = addr_reg - rd_data.start;
                state_next        = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        idx_reg  <= idx_next;
        func_reg <= func_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

    `SAL_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(TABLE_DEPTH), "entry count exceeds table depth")
    `SAL_ASSERT(a_write_state, !req.we || state_reg == S_SHIFT || state_reg == S_INSERT, "table written outside shift or insert")
    `SAL_ASSERT(a_search_order, !(state_reg == S_PROBE || state_reg == S_CMP) || lo_reg <= hi_reg, "search bounds crossed")
    `SAL_ASSERT_NEXT(a_cmp_after_probe, state_reg == S_PROBE && lo_reg < hi_reg, state_reg == S_CMP, "probe read not followed by compare")
    `SAL_ASSERT_NEXT(a_insert_count, state_reg == S_INSERT, cnt_reg == $past(cnt_reg) + CNT_W'(1), "insert did not advance the count")

endmodule

// ===== rtl/symbol_address_lookup_top.sv =====
// Symbol address lookup block: a sorted table of symbol start addresses with a
// search for the last entry whose start is at or below a query address. A load
// item stores a nonzero address with type 't' or 'T' in sorted order, after any
// equal starts, and returns its tag (the load sequence number). A lookup item
// returns the matching tag and the offset from that entry's start, or not-found.
// One item is worked at a time. Each probe of the binary search is a registered
// read of the table's single read port followed by a compare. A load runs the
// same search and then moves every stored entry above the insertion point up by
// one, one entry per cycle through the table's read and write ports, starting
// from the last entry; the new entry is then written at the insertion point. A
// rejected load (zero address, other type or full table) goes straight to the
// output stage. The result sits in an output register, so the next item may
// be accepted while a result still waits.
module symbol_address_lookup_top import sal_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [ADDR_W-1:0] s_addr,
    input  logic [TYPE_W-1:0] s_sym_type,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_accepted,
    output logic              m_found,
    output logic [TAG_W-1:0]  m_tag,
    output logic [ADDR_W-1:0] m_offset
);

    mem_req_t req;
    entry_t   rd_data;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic     m_valid_reg, m_valid_next;
    result_t  out_reg;

    sal_table u_table (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    sal_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_addr     (s_addr),
        .s_sym_type (s_sym_type),
        .req        (req),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_accepted = out_reg.accepted;
    assign m_found    = out_reg.found;
    assign m_tag      = out_reg.tag;
    assign m_offset   = out_reg.offset;

endmodule

// ===== tb/sv/tb_symbol_address_lookup_top.sv =====
// Self-checking testbench for symbol_address_lookup_top: drives load and lookup items,
// predicts every result with its own sorted symbol table and compares field by field.
// Depends on sal_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_symbol_address_lookup_top;
    import sal_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0] ADDR_TOP  = {1'b1, {(ADDR_W-1){1'b0}}};

    typedef struct {
        logic              func;
        logic [ADDR_W-1:0] addr;
        logic [TYPE_W-1:0] sym_type;
    } sym_item_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_func = FUNC_LOAD;
    logic [ADDR_W-1:0] s_addr = '0;
    logic [TYPE_W-1:0] s_sym_type = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_accepted;
    logic              m_found;
    logic [TAG_W-1:0]  m_tag;
    logic [ADDR_W-1:0] m_offset;

    symbol_address_lookup_top uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_addr     (s_addr),
        .s_sym_type (s_sym_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_accepted (m_accepted),
        .m_found    (m_found),
        .m_tag      (m_tag),
        .m_offset   (m_offset)
    );

    sym_item_t         pending_items[$];
    result_t           symbol_results_due[$];
    logic [ADDR_W-1:0] known_starts[$];

    // Predicted symbol table.
    logic [ADDR_W-1:0] start_mem [TABLE_DEPTH];
    logic [TAG_W-1:0]  tag_mem [TABLE_DEPTH];
    int unsigned       stored_count = 0;

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        item_taken = 1'b0;
    logic        rx_hold_req = 1'b0;
    logic        rx_hold_spent = 1'b0;
    int unsigned rx_hold_left = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        $display("mismatch in %s at cycle %0d: got %h, expected %h",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // Number of stored entries whose start is at or below the address.
    function automatic int unsigned entries_at_or_below(input logic [ADDR_W-1:0] a);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = stored_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (start_mem[mid] <= a)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    task automatic predict_symbol_result(input logic func, input logic [ADDR_W-1:0] a,
                                         input logic [TYPE_W-1:0] t, output result_t r);
        int unsigned pos;
        r = '0;
        if (func == FUNC_LOAD) begin
            if (a != '0 && (t == TYPE_LOWER_T || t == TYPE_UPPER_T) &&
                stored_count < TABLE_DEPTH) begin
                // Equal starts go after the ones already stored.
                pos = entries_at_or_below(a);
                for (int i = int'(stored_count); i > int'(pos); i--) begin
                    start_mem[i] = start_mem[i-1];
                    tag_mem[i]   = tag_mem[i-1];
                end
                start_mem[pos] = a;
                tag_mem[pos]   = stored_count[TAG_W-1:0];
                r.accepted     = 1'b1;
                r.tag          = stored_count[TAG_W-1:0];
                stored_count++;
            end
        end else begin
            pos = entries_at_or_below(a);
            if (pos != 0) begin
                r.found  = 1'b1;
                r.tag    = tag_mem[pos-1];
                r.offset = a - start_mem[pos-1];
            end
        end
    endtask

    task automatic push_item(input logic func, input logic [ADDR_W-1:0] a,
                             input logic [TYPE_W-1:0] t);
        sym_item_t it;
        it.func     = func;
        it.addr     = a;
        it.sym_type = t;
        pending_items.push_back(it);
        if (func == FUNC_LOAD && a != '0 && (t == TYPE_LOWER_T || t == TYPE_UPPER_T)) begin
            known_starts.push_back(a);
        end
    endtask

    task automatic push_random_items(input int count);
        logic              func;
        logic [ADDR_W-1:0] a;
        logic [TYPE_W-1:0] t;
        int unsigned       pick;
        repeat (count) begin
            func = $urandom_range(1) ? FUNC_LOOKUP : FUNC_LOAD;
            pick = $urandom_range(99);
            if (pick < 35) begin
                a = ADDR_W'($urandom_range(300));
            end else if (pick < 60 && known_starts.size() != 0) begin
                // Land on, just below or just above a start that was loaded.
                a = known_starts[$urandom_range(known_starts.size() - 1)];
                a = a + ADDR_W'($urandom_range(8)) - ADDR_W'(2);
            end else if (pick < 90) begin
                a = {$urandom, $urandom};
            end else begin
                case ($urandom_range(3))
                    0: a = '0;
                    1: a = ADDR_ONES;
                    2: a = ADDR_TOP;
                    default: a = ADDR_TOP - 1;
                endcase
            end
            if ($urandom_range(99) < 75)
                t = $urandom_range(1) ? TYPE_LOWER_T : TYPE_UPPER_T;
            else
                t = TYPE_W'($urandom_range(255));
            push_item(func, a, t);
        end
    endtask

    // Checked at the rising edge, where the sender's signals are stable.
    task automatic wait_until_drained();
        while (pending_items.size() != 0 || s_valid || symbol_results_due.size() != 0)
            @(posedge aclk);
    endtask

    // Sender: a new item goes out once the previous one was taken.
    always @(negedge aclk) begin : drive_items
        sym_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = pending_items.pop_front();
                s_valid    <= 1'b1;
                s_func     <= nxt.func;
                s_addr     <= nxt.addr;
                s_sym_type <= nxt.sym_type;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver.
    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off, started once on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold_left  <= 0;
            rx_hold_spent <= 1'b0;
        end else if (rx_hold_req && !rx_hold_spent) begin
            rx_hold_left  <= HOLD_CYCLES;
            rx_hold_spent <= 1'b1;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Monitor: check results first, then predict the item taken at this edge.
    always @(posedge aclk) begin : check_results
        result_t due;
        result_t fresh;
        if (!aresetn) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (symbol_results_due.size() == 0) begin
                    report_mismatch("unexpected result", ADDR_W'(m_tag), '0);
                end else begin
                    due = symbol_results_due.pop_front();
                    if (m_accepted !== due.accepted)
                        report_mismatch("accepted", ADDR_W'(m_accepted),
                                        ADDR_W'(due.accepted));
                    if (m_found !== due.found)
                        report_mismatch("found", ADDR_W'(m_found), ADDR_W'(due.found));
                    if (m_tag !== due.tag)
                        report_mismatch("tag", ADDR_W'(m_tag), ADDR_W'(due.tag));
                    if (m_offset !== due.offset)
                        report_mismatch("offset", m_offset, due.offset);
                end
            end
            if (s_valid && s_ready) begin
                predict_symbol_result(s_func, s_addr, s_sym_type, fresh);
                symbol_results_due.push_back(fresh);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Sender idles often, receiver idles more.
        tx_idle_pct = 36;
        rx_idle_pct = 69;
        push_item(FUNC_LOOKUP, '0, '0);
        push_item(FUNC_LOOKUP, ADDR_ONES, 8'hFF);
        push_item(FUNC_LOAD, '0, TYPE_LOWER_T);
        push_item(FUNC_LOAD, 64'h1000, 8'h78);
        push_item(FUNC_LOAD, 64'h1000, TYPE_UPPER_T);
        push_item(FUNC_LOAD, 64'h1000, TYPE_LOWER_T);
        push_item(FUNC_LOAD, 64'h1, TYPE_LOWER_T);
        push_item(FUNC_LOAD, ADDR_ONES, TYPE_UPPER_T);
        push_item(FUNC_LOAD, ADDR_TOP, TYPE_LOWER_T);
        push_item(FUNC_LOOKUP, '0, TYPE_LOWER_T);
        push_item(FUNC_LOOKUP, 64'h1, '0);
        push_item(FUNC_LOOKUP, 64'hFFF, '0);
        push_item(FUNC_LOOKUP, 64'h1000, '0);
        push_item(FUNC_LOOKUP, ADDR_TOP - 1, '0);
        push_item(FUNC_LOOKUP, ADDR_TOP, '0);
        push_item(FUNC_LOOKUP, ADDR_ONES, '0);
        push_item(FUNC_LOAD, ADDR_ONES, 8'hFF);
        push_item(FUNC_LOAD, 64'h2000, 8'h00);
        push_item(FUNC_LOAD, ADDR_TOP, TYPE_UPPER_T);
        push_item(FUNC_LOOKUP, ADDR_TOP + 1, '0);
        push_random_items(190);
        wait_until_drained();

        // Roles swapped, with one long receiver hold-off while items keep coming.
        tx_idle_pct = 69;
        rx_idle_pct = 36;
        push_random_items(200);
        rx_hold_req = 1'b1;
        wait_until_drained();

        // Full speed to finish.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_random_items(200);
        push_item(FUNC_LOAD, 64'h5, TYPE_LOWER_T);
        push_item(FUNC_LOAD, ADDR_ONES, TYPE_UPPER_T);
        push_item(FUNC_LOOKUP, ADDR_ONES, '0);
        push_random_items(16);
        wait_until_drained();

        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && symbol_results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
